@@ rtl/sorted_array_priority_queue_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sorted-array priority queue
// ---------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SPQC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define SPQC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/spqc_pkg.sv @@
// ---------------------------------------------------------------------------
// spqc_pkg
// Shared types and codes of the sorted-array priority queue.
// ---------------------------------------------------------------------------
`default_nettype none

package spqc_pkg;

   // Operation codes
   localparam logic [1:0] OP_ENQ  = 2'd0;
   localparam logic [1:0] OP_DEQ  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam int DATA_W = 32;
   localparam int PRI_W  = 16;
   localparam int OCC_W  = 7;

   // One stored entry
   typedef struct packed {
      logic        [DATA_W-1:0] data;
      logic signed [PRI_W-1:0]  pri;
   } entry_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/spqc_cell.sv @@
// ---------------------------------------------------------------------------
// spqc_cell
// One slot of the sorted row: compares the broadcast priority with its own,
// then holds, takes the new entry, or shifts from a neighbour.
// ---------------------------------------------------------------------------
`default_nettype none

module spqc_cell (
   input  wire                  clock,
   input  spqc_pkg::cmd_type    cmd,
   input  wire                  occupied,
   input  wire                  left_pos_le,   // insertion point at or before left cell
   input  spqc_pkg::entry_type  left_entry,
   input  spqc_pkg::entry_type  right_entry,
   output logic                 pos_le,        // insertion point at or before this cell
   output spqc_pkg::entry_type  entry
);

   spqc_pkg::entry_type entry_ff;
   spqc_pkg::entry_type entry_in;

   // New entry goes in front of the first free or lower-priority slot
   assign pos_le = !occupied || (entry_ff.pri < cmd.item.pri);
   assign entry  = entry_ff;

   // Select next contents
   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (left_pos_le) begin
            entry_in = left_entry;
         end else if (pos_le) begin
            entry_in = cmd.item;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

@@ rtl/sorted_array_priority_queue_core.sv @@
// ---------------------------------------------------------------------------
// sorted_array_priority_queue_core
// Priority queue held as a row of compare cells sorted by descending
// priority; equal priorities leave in arrival order.
// Usage:
//   req channel carries one operation per item: enqueue, dequeue or peek.
//   rsp channel returns exactly one item per request, in order, with the
//   head data (dequeue/peek), a status code and the occupancy afterwards.
//   An enqueue into a full queue is dropped with status full; dequeue or
//   peek on an empty queue returns data 0 with status empty.
// Timing:
//   rsp_tvalid rises in the cycle after request acceptance; one item per
//   cycle while the result is not stalled, as every cell compares and shifts in the same cycle.
// Reset:
//   reset clears the entry count and the result valid flag; req_tready is
//   low while reset is high. Entries need no clearing pass.
// Stall:
//   The result register holds while rsp_tready is low; req_tready drops
//   until the held item is taken.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sorted_array_priority_queue_core_assert.svh"

module sorted_array_priority_queue_core #(
   parameter int DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [1:0] op, [33:2] data_in, [49:34] priority_req, [55:50] zero
   input  wire  [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [31:0] data_out, [33:32] status, [40:34] occupancy, [47:41] zero
   output logic [47:0] rsp_tdata
);

   localparam int CW = $clog2(DEPTH + 1);

   // Unpack request
   logic [1:0]                          req_op;
   logic [spqc_pkg::DATA_W-1:0]         req_data;
   logic signed [spqc_pkg::PRI_W-1:0]   req_pri;
   assign req_op   = req_tdata[1:0];
   assign req_data = req_tdata[33:2];
   assign req_pri  = $signed(req_tdata[49:34]);

   logic                       accept;
   logic [CW-1:0]              count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [spqc_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic                       is_full, is_empty;
   spqc_pkg::cmd_type          cmd;

   spqc_pkg::entry_type entries [DEPTH];
   logic                pos_le  [DEPTH];

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CW'(DEPTH));
   assign is_empty   = (count_ff == '0);

   // Broadcast command to the row
   always_comb begin
      cmd.enq       = accept && (req_op == spqc_pkg::OP_ENQ) && !is_full;
      cmd.deq       = accept && (req_op == spqc_pkg::OP_DEQ) && !is_empty;
      cmd.item.data = req_data;
      cmd.item.pri  = req_pri;
   end

   // Row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spqc_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CW'(i) < count_ff),
         .left_pos_le ((i == 0) ? 1'b0 : pos_le[(i == 0) ? 0 : i - 1]),
         .left_entry  (entries[(i == 0) ? 0 : i - 1]),
         .right_entry (entries[(i == DEPTH - 1) ? i : i + 1]),
         .pos_le      (pos_le[i]),
         .entry       (entries[i])
      );
   end

   // Count and result
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.enq) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - CW'(1);
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = spqc_pkg::ST_OK;
         unique case (req_op)
            spqc_pkg::OP_ENQ: begin
               if (is_full) begin
                  rsp_status_in = spqc_pkg::ST_FULL;
               end
            end
            spqc_pkg::OP_DEQ, spqc_pkg::OP_PEEK: begin
               if (is_empty) begin
                  rsp_status_in = spqc_pkg::ST_EMPTY;
               end else begin
                  rsp_data_in = entries[0].data;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, spqc_pkg::OCC_W'(count_ff), rsp_status_ff, rsp_data_ff};

   // Checks
   `SPQC_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count above depth")
   `SPQC_ASSERT_NEXT(a_full_keeps, clock, reset, accept && req_op == spqc_pkg::OP_ENQ && is_full, count_ff == $past(count_ff) && rsp_status_ff == spqc_pkg::ST_FULL, "full enqueue changed queue")
   `SPQC_ASSERT_NEXT(a_deq_count, clock, reset, cmd.deq, count_ff == $past(count_ff) - CW'(1), "dequeue did not decrement")
   `SPQC_ASSERT_SAME(a_no_both, clock, reset, 1'b1, !(cmd.enq && cmd.deq), "enqueue and dequeue together")

endmodule

`default_nettype wire
